// ===== hdl/obcr_pkg.sv =====
// Shared types and constants for the orange blob center refiner.
// No dependencies; imported by the top, the scan sequencer and the checker.
`default_nettype none

package obcr_pkg;

   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 512;
   localparam int MASK_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(MASK_DEPTH);
   localparam int EDGE_MARGIN = 2;
   localparam int FAR_MARGIN  = 3;
   localparam int MIN_DIM     = 8;

   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HORIZON_ROW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TOLERANCE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_EXTENT    = 3'd4;

   // request kinds (req_tuser)
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // derived configuration handed to the scan sequencer
   typedef struct packed {
      logic [9:0] width;
      logic [9:0] height;
      logic [9:0] bottom_lim;
      logic [9:0] right_lim;
      logic [9:0] horizon;
      logic [3:0] tol;
      logic [8:0] min_ext;
   } cfg_type;

   // single mask port request
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic              wdata;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== hdl/orange_blob_center_refiner.sv =====
// Orange blob center refiner. A query reads mask pixels over the four scans;
// each read passes a CHECK state, which issues the RAM address, and a WAIT
// state, which waits out the RAM read and updates the gap count. The input
// reopens with the result. A stalled result holds only a later query that
// has finished. Each scan reads its run extent plus gap_tolerance pixels.
// One query is in flight at a time. Synchronous reset restores register
// defaults and idles the sequencer; the mask RAM is not cleared.
// Depends on obcr_pkg, obcr_ram, obcr_scan.
`default_nettype none

module orange_blob_center_refiner (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // column[8:0], row[17:9], is_orange[18], run_top[27:19], run_bottom[37:28]
   input  wire logic [obcr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[0]
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // center_x[8:0], center_y[17:9], accepted[18]
   output logic      [obcr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [obcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [obcr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import obcr_pkg::*;

   logic [9:0] image_width_ff,  image_width_in;
   logic [9:0] image_height_ff, image_height_in;
   logic [8:0] horizon_row_ff,  horizon_row_in;
   logic [3:0] gap_tol_ff,      gap_tol_in;
   logic [8:0] min_extent_ff,   min_extent_in;

   cfg_type     cfg;
   mem_req_type mem_req;
   logic        mem_rdata;

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      horizon_row_in  = horizon_row_ff;
      gap_tol_in      = gap_tol_ff;
      min_extent_in   = min_extent_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT:  image_height_in = csr_wdata;
            CSR_HORIZON_ROW:   horizon_row_in  = csr_wdata[8:0];
            CSR_GAP_TOLERANCE: gap_tol_in      = csr_wdata[3:0];
            CSR_MIN_EXTENT:    min_extent_in   = csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 10'd320;
         image_height_ff <= 10'd240;
         horizon_row_ff  <= 9'd0;
         gap_tol_ff      <= 4'd5;
         min_extent_ff   <= 9'd3;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         horizon_row_ff  <= horizon_row_in;
         gap_tol_ff      <= gap_tol_in;
         min_extent_ff   <= min_extent_in;
      end
   end

   always_comb begin
      cfg.width  = (image_width_ff < 10'(MIN_DIM)) ? 10'(MIN_DIM) :
                   (image_width_ff > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : image_width_ff;
      cfg.height = (image_height_ff < 10'(MIN_DIM)) ? 10'(MIN_DIM) :
                   (image_height_ff > 10'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : image_height_ff;
      cfg.bottom_lim = cfg.height - 10'(FAR_MARGIN);
      cfg.right_lim  = cfg.width - 10'(FAR_MARGIN);
      cfg.horizon    = ({1'b0, horizon_row_ff} < 10'(EDGE_MARGIN)) ? 10'(EDGE_MARGIN) :
                       ({1'b0, horizon_row_ff} > cfg.bottom_lim) ? cfg.bottom_lim
                                                                 : {1'b0, horizon_row_ff};
      cfg.tol        = gap_tol_ff;
      cfg.min_ext    = min_extent_ff;
   end

   obcr_ram #(
      .WIDTH (1),
      .DEPTH (MASK_DEPTH)
   ) u_mask (
      .clock (clock),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   obcr_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

endmodule

`default_nettype wire

// ===== hdl/obcr_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module obcr_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/obcr_scan.sv =====
// Query sequencer: walks the four pixel scans through the mask RAM, drives
// mask writes while idle and holds the result beat. Depends on obcr_pkg.
`default_nettype none

module obcr_scan (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire obcr_pkg::cfg_type               cfg,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [obcr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [obcr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output obcr_pkg::mem_req_type                mem_req,
   input  wire logic                            mem_rdata
);
   import obcr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      PH_DOWN  = 4'b0001,
      PH_UP    = 4'b0010,
      PH_LEFT  = 4'b0100,
      PH_RIGHT = 4'b1000
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [9:0] pos_ff, pos_in;
   logic [3:0] gap_ff, gap_in;
   logic [8:0] x_ff, x_in;
   logic [8:0] y_ff, y_in;
   logic [9:0] lower_ff, lower_in;
   logic [9:0] upper_ff, upper_in;
   logic [9:0] left_ff, left_in;
   logic [9:0] right_ff, right_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [8:0] rsp_x_ff, rsp_x_in;
   logic [8:0] rsp_y_ff, rsp_y_in;
   logic       rsp_ok_ff, rsp_ok_in;

   // request fields
   logic [8:0] f_column, f_row, f_top;
   logic       f_orange;
   logic [9:0] f_bottom;
   assign f_column = req_tdata[8:0];
   assign f_row    = req_tdata[17:9];
   assign f_orange = req_tdata[18];
   assign f_top    = req_tdata[27:19];
   assign f_bottom = req_tdata[37:28];

   logic        accept, run, rsp_free;
   logic [9:0]  end_sum;     // pos + gap + 1 for upward and leftward ends
   logic [9:0]  end_diff;    // pos - gap for downward and rightward ends
   logic [10:0] mid_sum;
   logic [9:0]  start_row;
   logic [9:0]  rd_row, rd_col;
   logic signed [10:0] span_x, span_y, min_s;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign end_sum    = pos_ff + 10'(gap_ff) + 10'd1;
   assign end_diff   = pos_ff - 10'(gap_ff);
   assign mid_sum    = (11'(f_top) + 11'(f_bottom)) >> 1;
   assign start_row  = (mid_sum > 11'(cfg.height - 10'd1)) ? (cfg.height - 10'd1)
                                                           : mid_sum[9:0];
   assign span_x     = $signed({1'b0, right_ff}) - $signed({1'b0, left_ff});
   assign span_y     = $signed({1'b0, lower_ff}) - $signed({1'b0, upper_ff});
   assign min_s      = $signed({2'b00, cfg.min_ext});

   always_comb begin
      run = 1'b0;
      unique case (phase_ff)
         PH_DOWN:  run = pos_ff <= cfg.bottom_lim;
         PH_UP:    run = pos_ff >= cfg.horizon;
         PH_LEFT:  run = pos_ff >= 10'(EDGE_MARGIN);
         PH_RIGHT: run = pos_ff <= cfg.right_lim;
         default:  run = 1'b0;
      endcase
      run = run && (gap_ff < cfg.tol);
   end

   // vertical scans walk rows on the query column, horizontal ones columns
   assign rd_row = (phase_ff == PH_DOWN || phase_ff == PH_UP) ? pos_ff : {1'b0, y_ff};
   assign rd_col = (phase_ff == PH_DOWN || phase_ff == PH_UP) ? {1'b0, x_ff} : pos_ff;

   always_comb begin
      mem_req.we    = 1'b0;
      mem_req.wdata = f_orange;
      if (state_ff == ST_IDLE) begin
         mem_req.addr = ADDR_W'(int'(f_row) * MAX_WIDTH + int'(f_column));
         mem_req.we   = accept && (req_tuser == KIND_WRITE) &&
                        (int'(f_column) < MAX_WIDTH) && (int'(f_row) < MAX_HEIGHT);
      end else begin
         mem_req.addr = ADDR_W'(int'(rd_row) * MAX_WIDTH + int'(rd_col));
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      gap_in       = gap_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_ok_in    = rsp_ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tuser == KIND_QUERY) begin
               x_in     = ({1'b0, f_column} > cfg.width - 10'd1) ? 9'(cfg.width - 10'd1)
                                                                 : f_column;
               y_in     = start_row[8:0];
               pos_in   = start_row;
               gap_in   = '0;
               phase_in = PH_DOWN;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (run) begin
               state_in = ST_WAIT;
            end else begin
               gap_in = '0;
               unique case (phase_ff)
                  PH_DOWN: begin
                     lower_in = end_diff;
                     pos_in   = {1'b0, y_ff};
                     phase_in = PH_UP;
                  end
                  PH_UP: begin
                     upper_in = end_sum;
                     y_in     = 9'((11'(lower_ff) + 11'(end_sum)) >> 1);
                     pos_in   = {1'b0, x_ff};
                     phase_in = PH_LEFT;
                  end
                  PH_LEFT: begin
                     left_in  = end_sum;
                     pos_in   = {1'b0, x_ff};
                     phase_in = PH_RIGHT;
                  end
                  PH_RIGHT: begin
                     right_in = end_diff;
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WAIT: begin
            gap_in   = mem_rdata ? 4'd0 : gap_ff + 4'd1;
            pos_in   = (phase_ff == PH_UP || phase_ff == PH_LEFT) ? pos_ff - 10'd1
                                                                  : pos_ff + 10'd1;
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = 9'((11'(left_ff) + 11'(right_ff)) >> 1);
               rsp_y_in     = y_ff;
               rsp_ok_in    = (span_x >= min_s) && (span_y >= min_s);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_DOWN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff   <= pos_in;
      gap_ff   <= gap_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      lower_ff <= lower_in;
      upper_ff <= upper_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ok_ff, rsp_y_ff, rsp_x_ff};

endmodule

`default_nettype wire

// ===== hdl/obcr_checker.sv =====
// Port-level checks for the orange blob center refiner, bound to the top.
// Depends on obcr_pkg and orange_blob_center_refiner.
`default_nettype none

module obcr_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             req_tuser,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [obcr_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import obcr_pkg::*;

   // a stalled result beat stays up and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // a mask write never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_WRITE && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result after mask write");

   // one query in flight: input closes after a query beat
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_QUERY |=> !req_tready)
      else $error("input open during query");

endmodule

bind orange_blob_center_refiner obcr_checker u_obcr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for orange_blob_center_refiner: paints mask pixels, queries orange runs and
// checks every spot against its own scan predictor. Depends on obcr_pkg and the RTL.

module tb;
   import obcr_pkg::*;

   typedef struct packed {
      logic       acc;
      logic [8:0] y;
      logic [8:0] x;
   } spot_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow of the block: mask, which pixels were written, registers
   bit         pix_orange [MASK_DEPTH];
   bit         pix_known  [MASK_DEPTH];
   logic [9:0] cfg_width   = 10'd320;
   logic [9:0] cfg_height  = 10'd240;
   logic [8:0] cfg_horizon = 9'd0;
   logic [3:0] cfg_tol     = 4'd5;
   logic [8:0] cfg_min_ext = 9'd3;

   spot_type spot_q[$];
   int    fail_count   = 0;
   int    items_sent   = 0;
   int    queries_sent = 0;
   bit    quiet_mode   = 1'b0;
   bit    miss_hit;
   int    miss_x, miss_y;

   orange_blob_center_refiner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (quiet_mode)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_dim(int v, int maxv);
      if (v < MIN_DIM)
         return MIN_DIM;
      if (v > maxv)
         return maxv;
      return v;
   endfunction

   // an unwritten pixel is flagged so the caller can paint it before querying
   function automatic bit orange_at(int x, int y);
      int a;
      a = y * MAX_WIDTH + x;
      if (!pix_known[a]) begin
         if (!miss_hit) begin
            miss_hit = 1'b1;
            miss_x   = x;
            miss_y   = y;
         end
         return 1'b0;
      end
      return pix_orange[a];
   endfunction

   function automatic spot_type refine_spot(int col, int top, int bot);
      int    w, h, bottom_lim, right_lim, horizon, tol, min_ext;
      int    x, y, gap, lower, upper, left, right;
      spot_type s;
      w          = clamp_dim(cfg_width, MAX_WIDTH);
      h          = clamp_dim(cfg_height, MAX_HEIGHT);
      bottom_lim = h - FAR_MARGIN;
      right_lim  = w - FAR_MARGIN;
      horizon    = cfg_horizon;
      if (horizon < EDGE_MARGIN)
         horizon = EDGE_MARGIN;
      if (horizon > bottom_lim)
         horizon = bottom_lim;
      tol     = cfg_tol;
      min_ext = cfg_min_ext;

      x = (col > w - 1) ? w - 1 : col;
      y = (top + bot) / 2;
      if (y > h - 1)
         y = h - 1;

      lower = y;
      gap   = 0;
      while (lower <= bottom_lim && gap < tol) begin
         gap = orange_at(x, lower) ? 0 : gap + 1;
         lower++;
      end
      lower -= gap;

      upper = y;
      gap   = 0;
      while (upper >= horizon && gap < tol) begin
         gap = orange_at(x, upper) ? 0 : gap + 1;
         upper--;
      end
      upper += gap + 1;

      y    = (lower + upper) / 2;
      left = x;
      gap  = 0;
      while (left >= EDGE_MARGIN && gap < tol) begin
         gap = orange_at(left, y) ? 0 : gap + 1;
         left--;
      end
      left += gap + 1;

      right = x;
      gap   = 0;
      while (right <= right_lim && gap < tol) begin
         gap = orange_at(right, y) ? 0 : gap + 1;
         right++;
      end
      right -= gap;

      x     = (left + right) / 2;
      s.x   = x[8:0];
      s.y   = y[8:0];
      s.acc = (right - left) >= min_ext && (lower - upper) >= min_ext;
      return s;
   endfunction

   task automatic send_beat(logic kind, int col, int row, int orange, int top, int bot);
      int                    gap;
      logic [REQ_DATA_W-1:0] beat;
      gap         = pick_gap();
      beat        = '0;
      beat[8:0]   = col[8:0];
      beat[17:9]  = row[8:0];
      beat[18]    = orange[0];
      beat[27:19] = top[8:0];
      beat[37:28] = bot[9:0];
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= kind;
      do
         @(posedge clock);
      while (!req_tready);
      items_sent++;
   endtask

   task automatic paint_pixel(int x, int y, bit orange);
      pix_orange[y * MAX_WIDTH + x] = orange;
      pix_known[y * MAX_WIDTH + x]  = 1'b1;
      send_beat(KIND_WRITE, x, y, orange, $urandom_range(0, 511), $urandom_range(0, 1023));
   endtask

   // background around a query is painted lazily, mostly not orange
   task automatic run_query(int col, int top, int bot);
      spot_type s;
      bit    done;
      done = 1'b0;
      while (!done) begin
         miss_hit = 1'b0;
         s        = refine_spot(col, top, bot);
         if (miss_hit)
            paint_pixel(miss_x, miss_y, $urandom_range(0, 9) == 0);
         else
            done = 1'b1;
      end
      spot_q.push_back(s);
      queries_sent++;
      send_beat(KIND_QUERY, col, $urandom_range(0, 511), $urandom_range(0, 1), top, bot);
   endtask

   // drop valid, let every spot come back, then allow a trailing write to land
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (spot_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_INDEX_W-1:0] idx, int val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:   cfg_width   = val[9:0];
         CSR_IMAGE_HEIGHT:  cfg_height  = val[9:0];
         CSR_HORIZON_ROW:   cfg_horizon = val[8:0];
         CSR_GAP_TOLERANCE: cfg_tol     = val[3:0];
         CSR_MIN_EXTENT:    cfg_min_ext = val[8:0];
         default: ;
      endcase
   endtask

   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 0;
      if (r == 1)
         return 1023;
      if (r == 2)
         return MAX_WIDTH;
      if (r == 3)
         return $urandom_range(1, 7);
      return $urandom_range(8, 400);
   endfunction

   task automatic random_config();
      int r, h;
      wait_idle();
      set_reg(CSR_IMAGE_WIDTH, pick_dim());
      set_reg(CSR_IMAGE_HEIGHT, pick_dim());
      h = clamp_dim(cfg_height, MAX_HEIGHT);
      r = $urandom_range(0, 5);
      set_reg(CSR_HORIZON_ROW, (r == 0) ? 0 : (r == 1) ? 511 : $urandom_range(0, h / 2));
      r = $urandom_range(0, 11);
      set_reg(CSR_GAP_TOLERANCE, (r == 0) ? 0 : (r == 1) ? 15 : $urandom_range(1, 6));
      r = $urandom_range(0, 9);
      set_reg(CSR_MIN_EXTENT, (r == 0) ? 0 : (r == 1) ? 511 : $urandom_range(0, 12));
   endtask

   // small solid blob under reset settings; should be accepted
   task automatic test_default_blob();
      for (int yy = 30; yy <= 32; yy++)
         for (int xx = 20; xx <= 22; xx++)
            paint_pixel(xx, yy, 1'b1);
      run_query(21, 30, 33);
   endtask

   // no scan runs at all; also run midpoint and column beyond the frame
   task automatic test_zero_tolerance();
      wait_idle();
      set_reg(CSR_GAP_TOLERANCE, 0);
      run_query(0, 511, 1023);
      run_query(511, 0, 1);
   endtask

   // width clamps up to the minimum, height down to the maximum, horizon clamps to the bottom limit
   task automatic test_clamped_frame();
      wait_idle();
      set_reg(CSR_IMAGE_WIDTH, 0);
      set_reg(CSR_IMAGE_HEIGHT, 1023);
      set_reg(CSR_HORIZON_ROW, 511);
      set_reg(CSR_GAP_TOLERANCE, 1);
      set_reg(CSR_MIN_EXTENT, 0);
      run_query(7, 511, 512);
      run_query(1, 0, 1);
      run_query(300, 100, 101);
   endtask

   // widest frame, shortest height, longest gap run, unreachable extent
   task automatic test_wide_frame();
      wait_idle();
      set_reg(CSR_IMAGE_WIDTH, 1023);
      set_reg(CSR_IMAGE_HEIGHT, 0);
      set_reg(CSR_HORIZON_ROW, 0);
      set_reg(CSR_GAP_TOLERANCE, 15);
      set_reg(CSR_MIN_EXTENT, 511);
      run_query(511, 3, 4);
   endtask

   // a pixel set, cleared and set again must read as its last value
   task automatic test_overwrite();
      wait_idle();
      set_reg(CSR_IMAGE_WIDTH, 320);
      set_reg(CSR_IMAGE_HEIGHT, 240);
      set_reg(CSR_GAP_TOLERANCE, 2);
      set_reg(CSR_MIN_EXTENT, 0);
      paint_pixel(100, 50, 1'b1);
      paint_pixel(100, 50, 1'b0);
      paint_pixel(100, 50, 1'b1);
      paint_pixel(101, 50, 1'b0);
      run_query(100, 50, 51);
   endtask

   task automatic test_random_blobs();
      int first_item, first_query, w, h, bw, bh, bx, by, col, top, bot;
      first_item  = items_sent;
      first_query = queries_sent;
      while (items_sent - first_item < 500 || queries_sent - first_query < 40) begin
         quiet_mode = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 7) == 0)
            random_config();
         else if ($urandom_range(0, 9) == 0)
            wait_idle();
         w = clamp_dim(cfg_width, MAX_WIDTH);
         h = clamp_dim(cfg_height, MAX_HEIGHT);
         if ($urandom_range(0, 4) == 0) begin
            // scattered noise and a query anywhere
            repeat ($urandom_range(1, 4))
               paint_pixel($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 1));
            run_query($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(1, 1023));
         end else begin
            bw = $urandom_range(1, 6);
            bh = $urandom_range(1, 6);
            bx = $urandom_range(0, w - bw);
            by = $urandom_range(0, h - bh);
            for (int yy = by; yy < by + bh; yy++)
               for (int xx = bx; xx < bx + bw; xx++)
                  paint_pixel(xx, yy, $urandom_range(0, 99) < 85);
            repeat ($urandom_range(1, 3)) begin
               col = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
                                                 : bx + $urandom_range(0, bw - 1);
               if ($urandom_range(0, 5) == 0) begin
                  top = $urandom_range(0, 511);
                  bot = $urandom_range(1, 1023);
               end else begin
                  top = by + $urandom_range(0, bh - 1);
                  bot = top + $urandom_range(1, bh);
               end
               run_query(col, top, bot);
            end
         end
      end
      quiet_mode = 1'b0;
   endtask

   // result side stalls
   initial begin
      int n;
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      spot_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[18:0];
         if (spot_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected spot beat: x=%0d y=%0d acc=%0d", got.x, got.y, got.acc);
         end else begin
            want = spot_q.pop_front();
            if (got.x != want.x || got.y != want.y || got.acc != want.acc) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("spot mismatch: expected x=%0d y=%0d acc=%0d, got x=%0d y=%0d acc=%0d",
                           want.x, want.y, want.acc, got.x, got.y, got.acc);
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_blob();
      test_zero_tolerance();
      test_clamped_frame();
      test_wide_frame();
      test_overwrite();
      test_random_blobs();
      wait_idle();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && spot_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // full-frame scans on every query under long stalls stay well inside this
   initial begin
      #200_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
